FILE: rtl/sbpd_pkg.sv
// Shared types and constants for the servo bus packet deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sbpd_pkg;

    localparam logic [7:0]  SYNC_BYTE     = 8'h55;
    localparam logic [7:0]  SUM_GOOD      = 8'hFF;
    localparam logic [7:0]  MIN_LENGTH    = 8'd3;
    localparam logic [15:0] TIMEOUT_RESET = 16'd5;
    localparam logic [15:0] GAP_MAX       = 16'hFFFF;

    // positions of interest within a packet (sync bytes are 0 and 1)
    localparam logic [8:0] POS_HUNT   = 9'd0;
    localparam logic [8:0] POS_SYNC1  = 9'd1;
    localparam logic [8:0] POS_BODY   = 9'd2;
    localparam logic [8:0] POS_LENGTH = 9'd3;
    localparam logic [8:0] POS_DATA   = 9'd4;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CSUM_FAIL = 2'd1,
        ST_BAD_LEN   = 2'd2,
        ST_TIMEOUT   = 2'd3
    } t_status;

    typedef struct packed {
        t_op        operation;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] byte_value;
        logic [8:0] position;
        logic       last;
        t_status    status;
    } t_result;

endpackage

FILE: rtl/servo_bus_packet_deframer.sv
// Top level of the servo bus packet deframer.
// Depends on sbpd_pkg, sbpd_in_reg, sbpd_core, sbpd_out_reg.
`timescale 1ns / 1ps
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata[7:0] rx_byte, tuser[0] operation
//  m_axis    out  m_axis_tvalid/tready        tdata[7:0] byte_value, [16:8] position,
//                                             tlast last, tuser[1:0] status
//  cfg       in   i_cfg_wr_en (no wait)       i_cfg_wr_data[15:0] gap_timeout_ticks
//
//  One transaction per cycle sustained while m_axis does not stall. An item
//  accepted into the input register stays there while the core works on it,
//  and its result is loaded into the result register once that register has
//  room, which raises m_axis_tvalid; the result is then taken from there.
//  The per-item state update in the core sets the rate.
//  Synchronous active-low reset clears the pipeline valids and the framing
//  state and restores the gap timeout to 5 ticks.
//  A stall on m_axis holds the result register; the input register keeps
//  accepting until it is itself full, then s_axis_tready drops.
//
// Packet: 0x55 0x55 id len cmd data... chk; body positions count from 2, the
// last body byte sits at position len+2. Sum of id..chk must be 0xFF.

module servo_bus_packet_deframer import sbpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] operation (0 byte, 1 tick)
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] byte_value, [16:8] position, rest 0
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    advance;
    logic    out_free;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_item.operation = t_op'(s_axis_tuser[0]);
    assign in_item.rx_byte   = s_axis_tdata;

    // the core runs whenever the held item can leave: the result register has
    // room for whatever it produces (items without a result also wait for that room)
    assign advance = held_valid && out_free;

    sbpd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    sbpd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (advance),
        .i_item        (held_item),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    sbpd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {7'd0, out_res.position, out_res.byte_value};
    assign m_axis_tuser = out_res.status;
    assign m_axis_tlast = out_res.last;

endmodule

FILE: rtl/sbpd_in_reg.sv
// Input register of the deframer: holds one accepted transaction.
// Depends on sbpd_pkg.
`timescale 1ns / 1ps

module sbpd_in_reg import sbpd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_advance,   // core consumes the held item this cycle
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: rtl/sbpd_core.sv
// Deframer state and per-item update: sync hunt, length, checksum, gap timer.
// Depends on sbpd_pkg.
`timescale 1ns / 1ps

module sbpd_core import sbpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_fire,       // process i_item this cycle
    input  t_item       i_item,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic [15:0] r_gap_timeout;
    logic [8:0]  r_byte_index, n_byte_index;
    logic [8:0]  r_end_index,  n_end_index;
    logic [7:0]  r_sum,        n_sum;
    logic [15:0] r_gap_count,  n_gap_count;

    logic [15:0] gap_inc;
    logic [7:0]  sum_add;
    logic [8:0]  idx_inc;

    assign gap_inc = (r_gap_count != GAP_MAX) ? r_gap_count + 16'd1 : r_gap_count;
    assign sum_add = r_sum + i_item.rx_byte;
    assign idx_inc = r_byte_index + 9'd1;

    always_comb begin
        n_byte_index = r_byte_index;
        n_end_index  = r_end_index;
        n_sum        = r_sum;
        n_gap_count  = r_gap_count;
        o_res_valid  = 1'b0;
        o_res        = '{byte_value: 8'd0, position: 9'd0, last: 1'b0, status: ST_OK};

        if (i_fire) begin
            if (i_item.operation == OP_TICK) begin
                if (r_byte_index != POS_HUNT) begin
                    n_gap_count = gap_inc;
                    if (gap_inc >= r_gap_timeout) begin
                        n_byte_index = POS_HUNT;
                        n_end_index  = 9'd0;
                        n_sum        = 8'd0;
                        n_gap_count  = 16'd0;
                        o_res_valid  = 1'b1;
                        o_res.last   = 1'b1;
                        o_res.status = ST_TIMEOUT;
                    end
                end
            end else begin
                n_gap_count = 16'd0;
                if (r_byte_index == POS_HUNT) begin
                    if (i_item.rx_byte == SYNC_BYTE) begin
                        n_byte_index = POS_SYNC1;
                    end
                end else if (r_byte_index == POS_SYNC1) begin
                    if (i_item.rx_byte == SYNC_BYTE) begin
                        n_byte_index = POS_BODY;
                        n_sum        = 8'd0;
                        n_end_index  = 9'd0;
                    end else begin
                        n_byte_index = POS_HUNT;
                    end
                end else begin
                    o_res_valid      = 1'b1;
                    o_res.byte_value = i_item.rx_byte;
                    o_res.position   = r_byte_index;
                    n_sum            = sum_add;
                    n_byte_index     = idx_inc;
                    if (r_byte_index == POS_LENGTH) begin
                        n_end_index = {1'b0, i_item.rx_byte} + 9'd3;
                    end
                    if (r_byte_index == POS_LENGTH && i_item.rx_byte < MIN_LENGTH) begin
                        // short length byte: abort and resync
                        n_byte_index = POS_HUNT;
                        n_end_index  = 9'd0;
                        n_sum        = 8'd0;
                        o_res.last   = 1'b1;
                        o_res.status = ST_BAD_LEN;
                    end else if (r_byte_index >= POS_DATA && idx_inc == r_end_index) begin
                        n_byte_index = POS_HUNT;
                        n_end_index  = 9'd0;
                        n_sum        = 8'd0;
                        o_res.last   = 1'b1;
                        o_res.status = (sum_add == SUM_GOOD) ? ST_OK : ST_CSUM_FAIL;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_timeout <= TIMEOUT_RESET;
            r_byte_index  <= POS_HUNT;
            r_end_index   <= 9'd0;
            r_sum         <= 8'd0;
            r_gap_count   <= 16'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_gap_timeout <= i_cfg_wr_data;
            end
            r_byte_index <= n_byte_index;
            r_end_index  <= n_end_index;
            r_sum        <= n_sum;
            r_gap_count  <= n_gap_count;
        end
    end

endmodule

FILE: rtl/sbpd_out_reg.sv
// Result register of the deframer, drives the master-side stream.
// Depends on sbpd_pkg.
`timescale 1ns / 1ps

module sbpd_out_reg import sbpd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,      // a new result is written this cycle
    input  t_result i_res,
    output logic    o_free,      // register can take a result this cycle
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: rtl/sbpd_checker.sv
// Port-level checks for the servo bus packet deframer, bound to the top level.
// Depends on sbpd_pkg and servo_bus_packet_deframer.
`timescale 1ns / 1ps

module sbpd_checker import sbpd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a verdict other than ok only on the closing result
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tlast)
        else $error("error status without tlast");

    // timeout result carries no byte and no position
    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_TIMEOUT |-> m_axis_tdata == 24'd0)
        else $error("timeout result with nonzero data");

    // bad length is only reported on the length byte
    a_bad_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_BAD_LEN |->
            m_axis_tdata[16:8] == POS_LENGTH && m_axis_tdata[7:0] < MIN_LENGTH)
        else $error("bad length reported off the length byte");

    // body bytes never sit on the sync positions
    a_body_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_TIMEOUT |->
            m_axis_tdata[16:8] != POS_HUNT && m_axis_tdata[16:8] != POS_SYNC1)
        else $error("body byte at a sync position");

endmodule

bind servo_bus_packet_deframer sbpd_checker u_sbpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: sim/sbpd_deframe_check.sv
// Result checker for the servo bus packet deframer testbench.
// Depends on sbpd_pkg; watches the cfg, input and result channels of the block.
`timescale 1ns / 1ps

module sbpd_deframe_check import sbpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    input  logic [7:0]  i_in_tdata,   // [7:0] rx_byte
    input  logic [0:0]  i_in_tuser,   // [0] operation
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    input  logic [23:0] i_out_tdata,  // [7:0] byte_value, [16:8] position, rest 0
    input  logic [1:0]  i_out_tuser,  // [1:0] status
    input  logic        i_out_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    // shadow of the framing state
    logic [15:0] gap_limit;
    logic [8:0]  frame_pos;
    logic [8:0]  frame_end;
    logic [7:0]  body_sum;
    logic [15:0] tick_gap;

    t_result expected_q[$];
    int      mismatch_count = 0;
    int      outstanding = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = outstanding;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: result mismatch, %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic resync();
        frame_pos = POS_HUNT;
        frame_end = '0;
        body_sum  = '0;
        tick_gap  = '0;
    endtask

    task automatic queue_result(input logic [7:0] value, input logic [8:0] pos,
                                input logic last, input t_status status);
        t_result r;
        r.byte_value = value;
        r.position   = pos;
        r.last       = last;
        r.status     = status;
        expected_q.push_back(r);
        outstanding++;
    endtask

    // one input transaction through the deframer
    task automatic deframe_item(input t_op op, input logic [7:0] rx);
        logic [8:0] pos;
        t_status    verdict;
        if (op == OP_TICK) begin
            if (frame_pos == POS_HUNT) return;
            if (tick_gap != GAP_MAX) tick_gap++;
            if (tick_gap >= gap_limit) begin
                resync();
                queue_result(8'd0, 9'd0, 1'b1, ST_TIMEOUT);
            end
            return;
        end
        tick_gap = '0;
        if (frame_pos == POS_HUNT) begin
            if (rx == SYNC_BYTE) frame_pos = POS_SYNC1;
        end else if (frame_pos == POS_SYNC1) begin
            if (rx == SYNC_BYTE) begin
                frame_pos = POS_BODY;
                body_sum  = '0;
                frame_end = '0;
            end else begin
                frame_pos = POS_HUNT;
            end
        end else begin
            pos      = frame_pos;
            body_sum = body_sum + rx;
            if (pos == POS_LENGTH && rx < MIN_LENGTH) begin
                resync();
                queue_result(rx, pos, 1'b1, ST_BAD_LEN);
                return;
            end
            if (pos == POS_LENGTH) frame_end = {1'b0, rx} + 9'd3;
            frame_pos = pos + 9'd1;
            if (pos >= POS_DATA && frame_pos == frame_end) begin
                verdict = (body_sum == SUM_GOOD) ? ST_OK : ST_CSUM_FAIL;
                resync();
                queue_result(rx, pos, 1'b1, verdict);
            end else begin
                queue_result(rx, pos, 1'b0, ST_OK);
            end
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_q.size() == 0) begin
            report_mismatch("result with nothing pending, tdata", i_out_tdata, 0);
            return;
        end
        want = expected_q.pop_front();
        outstanding--;
        if (i_out_tdata[7:0] != want.byte_value)
            report_mismatch("byte_value", i_out_tdata[7:0], want.byte_value);
        if (i_out_tdata[16:8] != want.position)
            report_mismatch("position", i_out_tdata[16:8], want.position);
        if (i_out_tdata[23:17] != '0)
            report_mismatch("tdata padding", i_out_tdata[23:17], 0);
        if (i_out_tlast != want.last)
            report_mismatch("last", i_out_tlast, want.last);
        if (i_out_tuser != want.status)
            report_mismatch("status", i_out_tuser, want.status);
    endtask

    // result first, then cfg, then the new input: a result never comes from
    // an input accepted at the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gap_limit = TIMEOUT_RESET;
            resync();
            expected_q.delete();
            outstanding = 0;
        end else begin
            if (i_out_tvalid && i_out_tready) check_result();
            if (i_cfg_wr_en) gap_limit = i_cfg_wr_data;
            if (i_in_tvalid && i_in_tready) deframe_item(t_op'(i_in_tuser[0]), i_in_tdata);
        end
    end

endmodule

FILE: sim/tb_servo_bus_packet_deframer.sv
// Testbench top for the servo bus packet deframer: clock, reset, stimulus, verdict.
// Depends on sbpd_pkg, servo_bus_packet_deframer and sbpd_deframe_check.
`timescale 1ns / 1ps

module tb_servo_bus_packet_deframer import sbpd_pkg::*;;

    // all block inputs start at known values
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] rx_byte
    logic [0:0]  s_axis_tuser  = '0;   // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [7:0] byte_value, [16:8] position, rest 0
    logic [1:0]  m_axis_tuser;         // [1:0] status
    logic        m_axis_tlast;

    int fail_count;
    int pending_results;

    // idle percentages of sender and receiver, changed per phase
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    // timeout value last written, used to size tick bursts
    int limit_now      = TIMEOUT_RESET;
    // transactions sent inside frames during the random part
    int framed_count   = 0;

    always #6 i_clk = ~i_clk;

    servo_bus_packet_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sbpd_deframe_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_tvalid   (s_axis_tvalid),
        .i_in_tready   (s_axis_tready),
        .i_in_tdata    (s_axis_tdata),
        .i_in_tuser    (s_axis_tuser),
        .i_out_tvalid  (m_axis_tvalid),
        .i_out_tready  (m_axis_tready),
        .i_out_tdata   (m_axis_tdata),
        .i_out_tuser   (m_axis_tuser),
        .i_out_tlast   (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending_results)
    );

    // receiver: a fresh stall decision every cycle
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    // One transaction on s_axis. Called and returns at a falling edge; tvalid
    // stays high on return so back-to-back items never toggle it.
    task automatic send_item(input t_op op, input logic [7:0] rx);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // ticks carry a random byte, which the block must ignore
    task automatic send_ticks(input int count);
        repeat (count) send_item(OP_TICK, 8'($urandom));
    endtask

    // Hold the sender until every pending result is out, then leave time for
    // an item still in flight that causes no result (two-stage pipeline).
    task automatic settle_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // gap timeout register, only ever written with the block idle
    task automatic write_gap_timeout(input logic [15:0] value);
        settle_pipeline();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        limit_now = value;
    endtask

    // Sync pair, id, length, then cmd/data/checksum with the checksum at
    // position len+2. Ticks may fall between body bytes; sometimes enough of
    // them to abandon the packet.
    task automatic send_frame(input logic [7:0] len, input bit bad_sum, input int tick_pct);
        logic [7:0] sum;
        logic [7:0] b;
        int         k;
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, SYNC_BYTE);
        b = 8'($urandom);
        send_item(OP_BYTE, b);
        sum = b;
        send_item(OP_BYTE, len);
        sum += len;
        framed_count += 4;
        if (len < MIN_LENGTH) return;
        for (k = 4; k <= int'(len) + 2; k++) begin
            if ($urandom_range(99) < tick_pct) begin
                if ($urandom_range(9) == 0) begin
                    // gap long enough to time the packet out
                    send_ticks(limit_now == 0 ? 1 : limit_now);
                    framed_count += (limit_now == 0 ? 1 : limit_now);
                    return;
                end else if (limit_now > 1) begin
                    send_ticks($urandom_range(limit_now - 1, 1));
                end
            end
            if (k == int'(len) + 2)
                b = 8'hFF - sum + (bad_sum ? 8'($urandom_range(255, 1)) : 8'd0);
            else
                b = 8'($urandom);
            send_item(OP_BYTE, b);
            sum += b;
            framed_count++;
        end
    endtask

    initial begin
        int          ph;
        int          stop_at;
        int          pick;
        int          lsel;
        logic [7:0]  len;
        int          src_by_phase[4]   = '{0, 62, 0, 11};
        int          sink_by_phase[4]  = '{0, 0, 62, 11};
        logic [15:0] limit_by_phase[4] = '{16'd3, 16'd1, 16'd0, 16'd12};

        // synchronous reset held from time zero, released on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed part, reset timeout of 5 ----
        send_item(OP_TICK, 8'hFF);              // tick while hunting: ignored
        send_item(OP_BYTE, SYNC_BYTE);          // lone sync then junk: dropped
        send_item(OP_BYTE, 8'h00);
        // shortest good packet: id 00, len 3, cmd FF, checksum FD
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h03);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'hFD);
        // same shape, checksum wrong
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h03);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h00);
        // length zero: bad length, back to hunting
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h00);
        // one sync byte already counts as an open packet for the gap timer
        send_item(OP_BYTE, SYNC_BYTE);
        send_ticks(5);

        // zero timeout: first tick of an open packet aborts it
        write_gap_timeout(16'd0);
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_TICK, 8'h00);

        // longer timeout, run all the way out
        write_gap_timeout(16'd40);
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, 8'h7E);
        send_ticks(40);

        // ---- random part, one idling profile per phase ----
        for (ph = 0; ph < 4; ph++) begin
            write_gap_timeout(limit_by_phase[ph]);   // also drains: sender pause
            src_idle_pct   = src_by_phase[ph];
            sink_stall_pct = sink_by_phase[ph];
            stop_at = framed_count + 430;
            while (framed_count < stop_at) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    lsel = $urandom_range(99);
                    if (lsel < 5)
                        len = 8'($urandom_range(2, 0));
                    else if (lsel < 10)
                        len = 8'($urandom_range(255, 11));
                    else
                        len = 8'($urandom_range(10, 3));
                    send_frame(len, $urandom_range(3) == 0, 15);
                end else if (pick < 90) begin
                    // line noise with stray sync bytes, may misframe what follows
                    repeat ($urandom_range(4, 1))
                        send_item(OP_BYTE, ($urandom_range(2) == 0) ? SYNC_BYTE
                                                                   : 8'($urandom));
                end else begin
                    // quiet line, sometimes with a half sync left to time out
                    if ($urandom_range(1) == 1) send_item(OP_BYTE, SYNC_BYTE);
                    send_ticks($urandom_range(limit_now + 1, 1));
                end
            end
        end

        // wind down: all results in, then a margin for anything stray
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        settle_pipeline();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_servo_bus_packet_deframer: done, clean");
        else
            $display("tb_servo_bus_packet_deframer: done, errors");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("tb_servo_bus_packet_deframer: done, errors");
        $finish;
    end

endmodule
